@@ hdl/segment_crossing_fraction_assert.svh @@
// Assertion macros for the segment crossing fraction block.
`ifndef SEGMENT_CROSSING_FRACTION_ASSERT_SVH
`define SEGMENT_CROSSING_FRACTION_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SCF_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SCF_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define SCF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

@@ hdl/scf_pkg.sv @@
// Shared types and constants for the segment crossing fraction block.
package scf_pkg;

    localparam int COORD_W    = 16;
    localparam int DIFF_W     = 17;
    localparam int WORD_W     = 32;
    localparam int QUOT_W     = 30;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [WORD_W-1:0] SAT_POS  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_NEG  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] NO_CROSS = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REG_SIGHT_START_X = 2'd0,
        REG_SIGHT_START_Y = 2'd1,
        REG_SIGHT_END_X   = 2'd2,
        REG_SIGHT_END_Y   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] wall_start_x;
        logic signed [COORD_W-1:0] wall_start_y;
        logic signed [COORD_W-1:0] wall_end_x;
        logic signed [COORD_W-1:0] wall_end_y;
    } wall_t;

    typedef struct packed {
        logic                     straddles;
        logic signed [WORD_W-1:0] crossing_fraction;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } sight_t;

    typedef struct packed {
        logic              straddle;
        logic [WORD_W-1:0] d1;
        logic [WORD_W-1:0] d2;
    } dot_t;

    typedef struct packed {
        logic              straddle;
        logic              neg;
        logic              sat;
        logic [WORD_W-1:0] ua;
        logic [WORD_W-1:0] ub;
        logic [WORD_W-1:0] rem;
        logic [QUOT_W-1:0] quot;
    } div_t;

endpackage

@@ hdl/scf_front.sv @@
// Geometry stages: coordinate differences, products, side test and dot products.
module scf_front import scf_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  sight_t sight,
    input  logic   in_valid,
    output logic   in_ready,
    input  wall_t  in_wall,
    output logic   out_valid,
    input  logic   out_ready,
    output dot_t   out_dot
);

    function automatic logic signed [DIFF_W-1:0] sdiff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        sdiff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    function automatic logic [WORD_W-1:0] mul32(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        logic signed [2*DIFF_W-1:0] p;
        p = a * b;
        mul32 = p[WORD_W-1:0];
    endfunction

    // stage A: differences
    logic                     a_valid_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [DIFF_W-1:0] ex1_reg, ey1_reg, nx_reg, ny_reg, sdx_reg, sdy_reg;
    // stage B: products
    logic              b_valid_reg;
    logic [WORD_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [WORD_W-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    // stage C: side test and dot products
    logic c_valid_reg;
    dot_t dot_reg;
    dot_t dot_next;

    logic ready_a, ready_b, ready_c;

    assign ready_c  = !c_valid_reg || out_ready;
    assign ready_b  = !b_valid_reg || ready_c;
    assign ready_a  = !a_valid_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (ready_a) a_valid_reg <= in_valid;
            if (ready_b) b_valid_reg <= a_valid_reg;
            if (ready_c) c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a && in_valid) begin
            dx1_reg <= sdiff(in_wall.wall_start_x, sight.start_x);
            dy1_reg <= sdiff(in_wall.wall_start_y, sight.start_y);
            dx2_reg <= sdiff(in_wall.wall_end_x, sight.start_x);
            dy2_reg <= sdiff(in_wall.wall_end_y, sight.start_y);
            ex1_reg <= sdiff(in_wall.wall_start_x, sight.end_x);
            ey1_reg <= sdiff(in_wall.wall_start_y, sight.end_y);
            nx_reg  <= sdiff(in_wall.wall_start_y, in_wall.wall_end_y);
            ny_reg  <= sdiff(in_wall.wall_end_x, in_wall.wall_start_x);
            sdx_reg <= sdiff(sight.end_x, sight.start_x);
            sdy_reg <= sdiff(sight.end_y, sight.start_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_b && a_valid_reg) begin
            pa_reg <= mul32(dy1_reg, sdx_reg);
            pb_reg <= mul32(dx1_reg, sdy_reg);
            pc_reg <= mul32(dy2_reg, sdx_reg);
            pd_reg <= mul32(dx2_reg, sdy_reg);
            m1_reg <= mul32(dx1_reg, nx_reg);
            m2_reg <= mul32(dy1_reg, ny_reg);
            m3_reg <= mul32(ex1_reg, nx_reg);
            m4_reg <= mul32(ey1_reg, ny_reg);
        end
    end

    always_comb begin
        dot_next.straddle = ($signed(pa_reg) > $signed(pb_reg))
                         != ($signed(pc_reg) > $signed(pd_reg));
        dot_next.d1       = m1_reg + m2_reg;
        dot_next.d2       = m3_reg + m4_reg;
    end

    always_ff @(posedge aclk) begin
        if (ready_c && b_valid_reg) begin
            dot_reg <= dot_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_dot   = dot_reg;

endmodule

@@ hdl/scf_div_prep.sv @@
// Divider setup stages: divisor, magnitudes, sign and saturation check.
module scf_div_prep import scf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  dot_t in_dot,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_div
);

    localparam int SHIFT = QUOT_W - FRAC_BITS;

    logic              d_valid_reg, e_valid_reg, f_valid_reg;
    logic              d_straddle_reg, e_straddle_reg, e_neg_reg;
    logic [WORD_W-1:0] d_d1_reg, d_dv_reg, e_ua_reg, e_ub_reg;
    div_t              div_reg;
    div_t              div_next;
    logic              ready_d, ready_e, ready_f;

    assign ready_f  = !f_valid_reg || out_ready;
    assign ready_e  = !e_valid_reg || ready_f;
    assign ready_d  = !d_valid_reg || ready_e;
    assign in_ready = ready_d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else begin
            if (ready_d) d_valid_reg <= in_valid;
            if (ready_e) e_valid_reg <= d_valid_reg;
            if (ready_f) f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_d && in_valid) begin
            d_straddle_reg <= in_dot.straddle;
            d_d1_reg       <= in_dot.d1;
            d_dv_reg       <= in_dot.d1 - in_dot.d2;
        end
        if (ready_e && d_valid_reg) begin
            e_straddle_reg <= d_straddle_reg;
            e_neg_reg      <= d_d1_reg[WORD_W-1] ^ d_dv_reg[WORD_W-1];
            e_ua_reg       <= d_d1_reg[WORD_W-1] ? (WORD_W'(0) - d_d1_reg) : d_d1_reg;
            e_ub_reg       <= d_dv_reg[WORD_W-1] ? (WORD_W'(0) - d_dv_reg) : d_dv_reg;
        end
        if (ready_f && e_valid_reg) begin
            div_reg <= div_next;
        end
    end

    // a zero divisor also lands here and saturates by the sign of d1
    always_comb begin
        div_next.straddle = e_straddle_reg;
        div_next.neg      = e_neg_reg;
        div_next.sat      = (e_ua_reg >> SHIFT) >= e_ub_reg;
        div_next.ua       = e_ua_reg;
        div_next.ub       = e_ub_reg;
        div_next.rem      = e_ua_reg >> SHIFT;
        div_next.quot     = '0;
    end

    assign out_valid = f_valid_reg;
    assign out_div   = div_reg;

endmodule

@@ hdl/scf_div_step.sv @@
// One restoring divide stage: settles a single quotient bit.
module scf_div_step import scf_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int BIT       = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_div,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_div
);

    logic              valid_reg;
    div_t              div_reg;
    div_t              div_next;
    logic              nbit;
    logic [WORD_W:0]   r2;
    logic [WORD_W+1:0] trial;
    logic              ge;

    // dividend is ua shifted up by the fraction width; bring down its next bit
    generate
        if (BIT >= FRAC_BITS) begin : g_dividend_bit
            assign nbit = in_div.ua[BIT-FRAC_BITS];
        end else begin : g_zero_bit
            assign nbit = 1'b0;
        end
    endgenerate

    always_comb begin
        r2              = {in_div.rem, nbit};
        trial           = {1'b0, r2} - {2'b00, in_div.ub};
        ge              = !trial[WORD_W+1];
        div_next        = in_div;
        div_next.rem    = ge ? trial[WORD_W-1:0] : r2[WORD_W-1:0];
        div_next.quot[BIT] = ge;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;

endmodule

@@ hdl/segment_crossing_fraction.sv @@
// Top level: APB registers, geometry stages, pipelined divider and output word.
//
// Finds where a wall segment crosses the sight segment held in four APB
// registers, as a signed fixed-point fraction with FRACTION_BITS fraction
// bits; a wall whose endpoints lie on one side of the sight line returns
// straddles = 0 and an all-ones fraction. One word is taken per cycle while
// the pipeline has room; each word's result passes through 3 geometry
// stages, 3 divider setup stages, 30 restoring divide stages, one bit each,
// and the output register, so an unstalled stream runs at one result per cycle.
// Each stage holds its word under backpressure and fills bubbles, so the
// input stays ready while any stage ahead has room. Write the sight
// registers only while no words are in flight.
`include "segment_crossing_fraction_assert.svh"

module segment_crossing_fraction import scf_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  wall_t                 s_wall,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_result
);

    sight_t     sight_reg;
    reg_index_t reg_sel;
    logic       cfg_write;

    logic front_valid, front_ready;
    dot_t front_dot;

    logic prep_ready;
    logic div_valid [QUOT_W+1];
    logic div_ready [QUOT_W+1];
    div_t div_word  [QUOT_W+1];

    logic              m_valid_reg;
    result_t           result_reg;
    result_t           result_next;
    logic              sat_reg;
    logic              out_ready;
    logic [WORD_W-1:0] quot_ext;
    div_t              last;

    // configuration port
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sight_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_SIGHT_START_X: sight_reg.start_x <= pwdata[COORD_W-1:0];
                REG_SIGHT_START_Y: sight_reg.start_y <= pwdata[COORD_W-1:0];
                REG_SIGHT_END_X:   sight_reg.end_x   <= pwdata[COORD_W-1:0];
                REG_SIGHT_END_Y:   sight_reg.end_y   <= pwdata[COORD_W-1:0];
                default:           sight_reg         <= sight_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SIGHT_START_X: prdata = CFG_DATA_W'(sight_reg.start_x);
            REG_SIGHT_START_Y: prdata = CFG_DATA_W'(sight_reg.start_y);
            REG_SIGHT_END_X:   prdata = CFG_DATA_W'(sight_reg.end_x);
            REG_SIGHT_END_Y:   prdata = CFG_DATA_W'(sight_reg.end_y);
            default:           prdata = '0;
        endcase
    end

    scf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sight     (sight_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_wall   (s_wall),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_dot   (front_dot)
    );

    scf_div_prep #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_dot    (front_dot),
        .out_valid (div_valid[0]),
        .out_ready (prep_ready),
        .out_div   (div_word[0])
    );

    assign prep_ready = div_ready[0];

    // quotient bits settle from the top down, one per stage
    genvar k;
    generate
        for (k = 0; k < QUOT_W; k++) begin : g_div
            scf_div_step #(
                .FRAC_BITS (FRACTION_BITS),
                .BIT       (QUOT_W - 1 - k)
            ) u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (div_valid[k]),
                .in_ready  (div_ready[k]),
                .in_div    (div_word[k]),
                .out_valid (div_valid[k+1]),
                .out_ready (div_ready[k+1]),
                .out_div   (div_word[k+1])
            );
        end
    endgenerate

    // output register
    assign out_ready          = !m_valid_reg || m_ready;
    assign div_ready[QUOT_W]  = out_ready;
    assign last               = div_word[QUOT_W];
    assign quot_ext           = WORD_W'(last.quot);

    always_comb begin
        result_next.straddles = last.straddle;
        priority if (!last.straddle) begin
            result_next.crossing_fraction = NO_CROSS;
        end else if (last.sat) begin
            result_next.crossing_fraction = last.neg ? SAT_NEG : SAT_POS;
        end else if (last.neg) begin
            result_next.crossing_fraction = WORD_W'(0) - quot_ext;
        end else begin
            result_next.crossing_fraction = quot_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= div_valid[QUOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && div_valid[QUOT_W]) begin
            result_reg <= result_next;
            sat_reg    <= last.sat;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    `SCF_ASSERT_IMPLY(a_no_cross_word, aclk, aresetn, m_valid && !m_result.straddles, m_result.crossing_fraction == NO_CROSS, "non-straddling word without all-ones fraction")
    `SCF_ASSERT_IMPLY(a_quot_range, aclk, aresetn, m_valid && m_result.straddles && !sat_reg, m_result.crossing_fraction[WORD_W-1] == m_result.crossing_fraction[WORD_W-2], "unsaturated quotient out of range")
    `SCF_ASSERT_IMPLY(a_empty_accepts, aclk, aresetn, !m_valid, s_ready, "input stalled with empty output register")
    `SCF_ASSERT_NEXT(a_cfg_start_x, aclk, aresetn, cfg_write && (reg_sel == REG_SIGHT_START_X), sight_reg.start_x == $past(pwdata[COORD_W-1:0]), "sight start x write lost")

endmodule

@@ test/tb_segment_crossing_fraction.sv @@
// Testbench for segment_crossing_fraction: random and directed walls checked against a predictor.
module tb_segment_crossing_fraction import scf_pkg::*; ();

    localparam int CLK_PERIOD = 20;
    localparam int FRAC_BITS  = 16;
    localparam int PHASE_WORDS = 105;

    // Expected crossing results, worked out from the current sight registers.
    class crossing_board;
        sight_t  sight;
        result_t expected_q[$];
        int      mismatches;

        function new();
            sight = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function result_t predict_crossing(wall_t w);
            logic [31:0] lx1, ly1, lx2, ly2, sx1, sy1, sx2, sy2;
            logic [31:0] sdx, sdy, nx, ny, d1, d2, den, ua, ub;
            logic [63:0] quo;
            logic        side1, side2, neg;
            result_t     r;
            lx1 = {{16{w.wall_start_x[15]}}, w.wall_start_x};
            ly1 = {{16{w.wall_start_y[15]}}, w.wall_start_y};
            lx2 = {{16{w.wall_end_x[15]}}, w.wall_end_x};
            ly2 = {{16{w.wall_end_y[15]}}, w.wall_end_y};
            sx1 = {{16{sight.start_x[15]}}, sight.start_x};
            sy1 = {{16{sight.start_y[15]}}, sight.start_y};
            sx2 = {{16{sight.end_x[15]}}, sight.end_x};
            sy2 = {{16{sight.end_y[15]}}, sight.end_y};
            sdx = sx2 - sx1;
            sdy = sy2 - sy1;
            // products wrap at 32 bits, compare as signed
            side1 = $signed((ly1 - sy1) * sdx) > $signed((lx1 - sx1) * sdy);
            side2 = $signed((ly2 - sy1) * sdx) > $signed((lx2 - sx1) * sdy);
            if (side1 == side2) begin
                r.straddles = 1'b0;
                r.crossing_fraction = NO_CROSS;
                return r;
            end
            nx  = ly1 - ly2;
            ny  = lx2 - lx1;
            d1  = (lx1 - sx1) * nx + (ly1 - sy1) * ny;
            d2  = (lx1 - sx2) * nx + (ly1 - sy2) * ny;
            den = d1 - d2;
            ua  = d1[31] ? 32'd0 - d1 : d1;
            ub  = den[31] ? 32'd0 - den : den;
            neg = d1[31] ^ den[31];
            r.straddles = 1'b1;
            // saturate on overflow, zero divisor included
            if ((ua >> (30 - FRAC_BITS)) >= ub) begin
                r.crossing_fraction = neg ? SAT_NEG : SAT_POS;
            end else begin
                quo = ({32'd0, ua} << FRAC_BITS) / {32'd0, ub};
                r.crossing_fraction = neg ? 32'd0 - quo[31:0] : quo[31:0];
            end
            return r;
        endfunction

        function void note_wall(wall_t w);
            expected_q.push_back(predict_crossing(w));
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual %b %h",
                         $time, got.straddles, got.crossing_fraction);
                mismatches++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.straddles !== exp_r.straddles) begin
                $display("%0t straddles mismatch: expected %b actual %b",
                         $time, exp_r.straddles, got.straddles);
                mismatches++;
            end
            if (got.crossing_fraction !== exp_r.crossing_fraction) begin
                $display("%0t crossing_fraction mismatch: expected %h actual %h",
                         $time, exp_r.crossing_fraction, got.crossing_fraction);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    wall_t                 s_wall;
    logic                  m_valid;
    logic                  m_ready;
    result_t               m_result;

    crossing_board board = new();
    wall_t         wall_q[$];
    int            src_idle_pct;
    int            sink_stall_pct;

    segment_crossing_fraction #(
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_wall(s_wall),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result(m_result)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_wall(s_wall);
        end
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_result);
        end
    end

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic wall_t mk_wall(int ax, int ay, int bx, int by);
        wall_t w;
        w.wall_start_x = clamp16(ax);
        w.wall_start_y = clamp16(ay);
        w.wall_end_x   = clamp16(bx);
        w.wall_end_y   = clamp16(by);
        return w;
    endfunction

    function automatic sight_t mk_sight(int ax, int ay, int bx, int by);
        sight_t s;
        s.start_x = clamp16(ax);
        s.start_y = clamp16(ay);
        s.end_x   = clamp16(bx);
        s.end_y   = clamp16(by);
        return s;
    endfunction

    // Mostly walls laid across the sight segment, some touching its line, some noise.
    function automatic wall_t random_wall(sight_t s);
        int t, px, py, dx, dy, sp, m, pick;
        wall_t w;
        pick = $urandom_range(0, 99);
        t  = int'($urandom_range(0, 320)) - 32;
        px = int'(s.start_x) + (int'(s.end_x) - int'(s.start_x)) * t / 256;
        py = int'(s.start_y) + (int'(s.end_y) - int'(s.start_y)) * t / 256;
        if (pick < 55) begin
            case ($urandom_range(0, 2))
                0: sp = 4;
                1: sp = 300;
                default: sp = 32767;
            endcase
            dx = int'($urandom_range(0, 2 * sp)) - sp;
            dy = int'($urandom_range(0, 2 * sp)) - sp;
            m  = $urandom_range(1, 8);
            w  = mk_wall(px + dx, py + dy, px - dx * m / 4, py - dy * m / 4);
        end else if (pick < 70) begin
            w = mk_wall(px, py, pick_coord(), pick_coord());
            if ($urandom_range(0, 1)) begin
                w = mk_wall(w.wall_end_x, w.wall_end_y, px, py);
            end
        end else begin
            w.wall_start_x = pick_coord();
            w.wall_start_y = pick_coord();
            w.wall_end_x   = pick_coord();
            w.wall_end_y   = pick_coord();
        end
        return w;
    endfunction

    function automatic sight_t make_sight(int ph);
        int x, y;
        x = int'(signed'(16'($urandom)));
        y = int'(signed'(16'($urandom)));
        case (ph)
            0: return mk_sight(-32768, -32768, 32767, 32767);
            1: return mk_sight(32767, -32768, -32768, 32767);
            2: return mk_sight(x, y, x + int'($urandom_range(0, 40)) - 20,
                               y + int'($urandom_range(0, 40)) - 20);
            3: return mk_sight(-32768, y, 32767, y);
            4: return mk_sight(x, -32768, x, 32767);
            5: return mk_sight(x, y, x, y);
            default: return mk_sight(x, y, int'(signed'(16'($urandom))),
                                     int'(signed'(16'($urandom))));
        endcase
    endfunction

    task automatic set_pace(int mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
            default: begin src_idle_pct = 17; sink_stall_pct = 17; end
        endcase
    endtask

    task automatic write_sight_reg(reg_index_t idx, logic signed [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        // upper bits carry no meaning, drive junk there
        pwdata  <= {16'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SIGHT_START_X: board.sight.start_x = val;
            REG_SIGHT_START_Y: board.sight.start_y = val;
            REG_SIGHT_END_X:   board.sight.end_x   = val;
            REG_SIGHT_END_Y:   board.sight.end_y   = val;
        endcase
    endtask

    task automatic load_sight(sight_t s);
        write_sight_reg(REG_SIGHT_START_X, s.start_x);
        write_sight_reg(REG_SIGHT_START_Y, s.start_y);
        write_sight_reg(REG_SIGHT_END_X, s.end_x);
        write_sight_reg(REG_SIGHT_END_Y, s.end_y);
    endtask

    task automatic send_wall(wall_t w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_wall  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Push every queued word, then hold until all their results are back.
    task automatic send_queued_walls();
        while (wall_q.size() > 0) begin
            send_wall(wall_q.pop_front());
        end
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() > 0);
    endtask

    initial begin
        #(CLK_PERIOD * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        s_valid <= 1'b0;
        s_wall  <= '0;
        set_pace(0);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset sight is a point: nothing straddles
        wall_q.push_back(mk_wall(-32768, -32768, 32767, 32767));
        wall_q.push_back(mk_wall(32767, -32768, -32768, 32767));
        wall_q.push_back(mk_wall(0, 0, 0, 0));
        send_queued_walls();

        // horizontal sight: plain crossings, same side, endpoint on the line
        load_sight(mk_sight(0, 0, 1000, 0));
        wall_q.push_back(mk_wall(500, -10, 500, 10));
        wall_q.push_back(mk_wall(500, 10, 500, -10));
        wall_q.push_back(mk_wall(500, 5, 600, 5));
        wall_q.push_back(mk_wall(500, -5, 600, -7));
        wall_q.push_back(mk_wall(500, 0, 500, 10));
        wall_q.push_back(mk_wall(250, -3, 251, 9));
        send_queued_walls();

        // unit sight: saturation past the end and behind the start
        load_sight(mk_sight(0, 0, 1, 0));
        wall_q.push_back(mk_wall(32767, -1, 32767, 1));
        wall_q.push_back(mk_wall(-32768, -1, -32768, 1));
        wall_q.push_back(mk_wall(0, -1, 0, 1));
        wall_q.push_back(mk_wall(1, 1, 1, -1));
        send_queued_walls();

        // full-range diagonal: wrapped side tests, zero divisor of both signs
        load_sight(mk_sight(-32768, -32768, 32767, 32767));
        wall_q.push_back(mk_wall(0, 1, -32768, -32767));
        wall_q.push_back(mk_wall(-32768, -32767, 0, 1));
        wall_q.push_back(mk_wall(-32768, -32768, 32767, 32767));
        wall_q.push_back(mk_wall(32767, -32768, -32768, 32767));
        wall_q.push_back(mk_wall(-32768, 32767, 32767, -32768));
        wall_q.push_back(mk_wall(32767, 32767, 32767, 32767));
        send_queued_walls();

        for (int ph = 0; ph < 8; ph++) begin
            load_sight(make_sight(ph));
            set_pace(ph % 4);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                wall_q.push_back(random_wall(board.sight));
            end
            send_queued_walls();
        end

        set_pace(0);
        repeat (50) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
